// ===== rtl/core/mcct_pkg.sv =====
// Shared widths, codes, sideband type and angle table for the collision test.
`default_nettype none
package mcct_pkg;

  // Input item and configuration formats
  localparam int POS_W      = 16;
  localparam int SPD_W      = 16;
  localparam int HDG_W      = 16;
  localparam int IN_DATA_W  = 8 * POS_W;
  localparam int OUT_DATA_W = 8;
  localparam int RAD_W      = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register index (word address) and reset value
  localparam logic [1:0]       REG_RADIUS   = 2'd0;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd13;

  // Verdict codes
  localparam logic [2:0] VERDICT_HIT    = 3'd0;
  localparam logic [2:0] VERDICT_FAR    = 3'd1;
  localparam logic [2:0] VERDICT_RECEDE = 3'd2;
  localparam logic [2:0] VERDICT_OFFSET = 3'd3;
  localparam logic [2:0] VERDICT_BEYOND = 3'd4;

  // CORDIC heading unit
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int CORD_W       = 18;
  localparam int CORD_FRAC    = 15;
  localparam int ANG_W        = 17;
  localparam int MUL_W        = 35;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 18'sd19899;

  // Datapath widths (Q.10 lengths)
  localparam int VEL_W   = 18;
  localparam int RVEL_W  = 19;
  localparam int DIFF_W  = 21;
  localparam int DOT_W   = 41;
  localparam int C2_W    = 42;
  localparam int M2_W    = 36;
  localparam int DIS_W   = 21;
  localparam int MAG_W   = 18;
  localparam int SPAN_W  = 17;
  localparam int SPAN2_W = 34;
  localparam int OFF_W   = 46;

  // Square root unit: one root bit per stage
  localparam int SQRT_IN_W   = 44;
  localparam int SQRT_OUT_W  = SQRT_IN_W / 2;
  localparam int SQRT_REM_W  = SQRT_OUT_W + 2;
  localparam int SQRT_STAGES = SQRT_OUT_W;

  // Divider: one quotient bit per stage
  localparam int DIV_DVD_W  = 40;
  localparam int DIV_DVS_W  = MAG_W;
  localparam int DIV_Q_W    = 22;
  localparam int DIV_STAGES = DIV_Q_W;

  // Values that ride along the long units
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [C2_W-1:0]         c2;
    logic [MAG_W-1:0]        mag;
    logic [DIV_Q_W-1:0]      proj;
    logic                    far;
    logic                    recede;
    logic                    offmiss;
  } side_t;

  // Arctangent steps in binary-angle units
  function automatic logic signed [ANG_W-1:0] atan_step(input logic [3:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mcct_cordic.sv =====
// One ball lane: pipelined CORDIC heading vector and speed scaling to velocity.
`default_nettype none
module mcct_cordic import mcct_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    ce,
  input  wire logic                    in_vld,
  input  wire logic [SPD_W-1:0]        in_speed,
  input  wire logic [HDG_W-1:0]        in_heading,
  output logic                         out_vld,
  output logic signed [VEL_W-1:0]      out_vx,
  output logic signed [VEL_W-1:0]      out_vy
);

  logic                     vld_r  [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] x_r    [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] y_r    [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]  z_r    [CORDIC_STEPS+1];
  logic                     flip_r [CORDIC_STEPS+1];
  logic [SPD_W-1:0]         spd_r  [CORDIC_STEPS+1];

  logic                     flip;
  logic [HDG_W-1:0]         hfold;
  logic                     vo_r;
  logic signed [VEL_W-1:0]  vx_r, vy_r;

  // Fold left half plane into right half; results get negated later
  assign flip  = in_heading[HDG_W-1] ^ in_heading[HDG_W-2];
  assign hfold = {in_heading[HDG_W-1] ^ flip, in_heading[HDG_W-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_vld;
    end
    if (ce) begin
      x_r[0]    <= CORDIC_X0;
      y_r[0]    <= '0;
      z_r[0]    <= ANG_W'($signed(hfold));
      flip_r[0] <= flip;
      spd_r[0]  <= in_speed;
    end
  end

  // Rotation stages, shifts round toward minus infinity
  for (genvar g = 1; g <= CORDIC_STEPS; g++) begin : g_rot
    logic signed [CORD_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]  step;
    logic                     dir;
    assign xs   = x_r[g-1] >>> (g - 1);
    assign ys   = y_r[g-1] >>> (g - 1);
    assign step = atan_step(4'(g - 1));
    assign dir  = !z_r[g-1][ANG_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (ce) begin
        vld_r[g] <= vld_r[g-1];
      end
      if (ce) begin
        x_r[g]    <= dir ? x_r[g-1] - ys : x_r[g-1] + ys;
        y_r[g]    <= dir ? y_r[g-1] + xs : y_r[g-1] - xs;
        z_r[g]    <= dir ? z_r[g-1] - step : z_r[g-1] + step;
        flip_r[g] <= flip_r[g-1];
        spd_r[g]  <= spd_r[g-1];
      end
    end
  end

  // Scale by speed: (speed * cos) >> 15 and (speed * sin) >> 15, floor
  logic signed [CORD_W-1:0] cs, sn;
  logic signed [SPD_W:0]    spd_s;
  logic signed [MUL_W-1:0]  prod_x, prod_y;

  assign cs     = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign sn     = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  assign spd_s  = $signed({1'b0, spd_r[CORDIC_STEPS]});
  assign prod_x = spd_s * cs;
  assign prod_y = spd_s * sn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ce) begin
      vo_r <= vld_r[CORDIC_STEPS];
    end
    if (ce) begin
      vx_r <= prod_x[CORD_FRAC+VEL_W-1:CORD_FRAC];
      vy_r <= prod_y[CORD_FRAC+VEL_W-1:CORD_FRAC];
    end
  end

  assign out_vld = vo_r;
  assign out_vx  = vx_r;
  assign out_vy  = vy_r;

endmodule
`default_nettype wire

// ===== rtl/core/mcct_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with sideband.
`default_nettype none
module mcct_sqrt import mcct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  ce,
  input  wire logic                  in_vld,
  input  wire logic [SQRT_IN_W-1:0]  in_rad,
  input  wire side_t                 in_side,
  output logic                       out_vld,
  output logic [SQRT_OUT_W-1:0]      out_root,
  output side_t                      out_side
);

  logic                   vld_r  [SQRT_STAGES];
  logic [SQRT_IN_W-1:0]   rad_r  [SQRT_STAGES];
  logic [SQRT_REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [SQRT_OUT_W-1:0]  root_r [SQRT_STAGES];
  side_t                  side_r [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic                  vld_i;
    logic [SQRT_IN_W-1:0]  rad_i;
    logic [SQRT_REM_W-1:0] rem_i;
    logic [SQRT_OUT_W-1:0] root_i;
    side_t                 side_i;
    logic [SQRT_REM_W-1:0] cur, trial;
    logic                  ge;

    if (g == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign side_i = side_r[g-1];
    end

    // Bring down two radicand bits, try (4*root + 1)
    assign cur   = {rem_i[SQRT_REM_W-3:0], rad_i[SQRT_IN_W-1-2*g -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (ce) begin
        vld_r[g] <= vld_i;
      end
      if (ce) begin
        rad_r[g]  <= rad_i;
        rem_r[g]  <= ge ? cur - trial : cur;
        root_r[g] <= {root_i[SQRT_OUT_W-2:0], ge};
        side_r[g] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STAGES-1];
  assign out_root = root_r[SQRT_STAGES-1];
  assign out_side = side_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/mcct_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module mcct_div import mcct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  ce,
  input  wire logic                  in_vld,
  input  wire logic [DIV_DVD_W-1:0]  in_dvd,
  input  wire logic [DIV_DVS_W-1:0]  in_dvs,
  input  wire side_t                 in_side,
  output logic                       out_vld,
  output logic [DIV_Q_W-1:0]         out_quo,
  output side_t                      out_side
);

  logic                  vld_r  [DIV_STAGES];
  logic [DIV_DVD_W-1:0]  dvd_r  [DIV_STAGES];
  logic [DIV_DVS_W-1:0]  dvs_r  [DIV_STAGES];
  logic [DIV_DVS_W-1:0]  rem_r  [DIV_STAGES];
  logic [DIV_Q_W-1:0]    quo_r  [DIV_STAGES];
  side_t                 side_r [DIV_STAGES];

  // Quotient is known to fit DIV_Q_W bits, so the top dividend bits start the remainder
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic                 vld_i;
    logic [DIV_DVD_W-1:0] dvd_i;
    logic [DIV_DVS_W-1:0] dvs_i;
    logic [DIV_DVS_W-1:0] rem_i;
    logic [DIV_Q_W-1:0]   quo_i;
    side_t                side_i;
    logic [DIV_DVS_W:0]   cur, diff;
    logic                 ge;

    if (g == 0) begin : g_first
      assign vld_i  = in_vld;
      assign dvd_i  = in_dvd;
      assign dvs_i  = in_dvs;
      assign rem_i  = in_dvd[DIV_DVD_W-1 -: DIV_DVS_W];
      assign quo_i  = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign dvd_i  = dvd_r[g-1];
      assign dvs_i  = dvs_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign quo_i  = quo_r[g-1];
      assign side_i = side_r[g-1];
    end

    assign cur  = {rem_i, dvd_i[DIV_Q_W-1-g]};
    assign diff = cur - {1'b0, dvs_i};
    assign ge   = (cur >= {1'b0, dvs_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (ce) begin
        vld_r[g] <= vld_i;
      end
      if (ce) begin
        dvd_r[g]  <= dvd_i;
        dvs_r[g]  <= dvs_i;
        rem_r[g]  <= ge ? diff[DIV_DVS_W-1:0] : cur[DIV_DVS_W-1:0];
        quo_r[g]  <= {quo_i[DIV_Q_W-2:0], ge};
        side_r[g] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_quo  = quo_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/moving_circle_collision_test.sv =====
// Top level: swept circle-circle collision test, fully pipelined.
// Usage:
//   in_* channel: one request per ball pair (positions Q10.6, speeds Q6.10,
//   binary-angle headings). out_* channel: one result per request, in order:
//   hit flag and a verdict code (hit, too far, receding, offset miss,
//   contact beyond step).
//   cfg_* port: APB-style; register 0 at byte address 0 holds the ball
//   radius in whole pixels (reset 13). Write it only while the block is idle.
// Timing:
//   One request per cycle sustained while out_tready stays high. A result
//   shows on out_tvalid once its request has passed the 16-stage CORDIC
//   lanes, three 22-stage root/quotient units, six arithmetic stages and the
//   output register.
// Reset (rst_n low, synchronous) empties the pipeline and the output register
// and loads the radius reset value.
// Stall: the pipeline keeps moving to fill empty slots while a result waits;
// once the last stage holds a result and out_tready is low, the whole pipe
// holds and in_tready drops. Nothing is lost or repeated.
`default_nettype none
module moving_circle_collision_test import mcct_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // tdata: first_x, first_y, first_speed, first_heading,
  //        second_x, second_y, second_speed, second_heading (16 bits each)
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  // tdata: hit [0], verdict [3:1], zero [7:4]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready
);

  // Configuration register
  logic [RAD_W-1:0]   radius_r;
  logic [SPAN_W-1:0]  span;
  logic [SPAN2_W-1:0] span2_r;
  logic [SPAN2_W-1:0] span2_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3:2] == REG_RADIUS) ?
                      {{(CFG_DATA_W-RAD_W){1'b0}}, radius_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[3:2] == REG_RADIUS) begin
      radius_r <= cfg_pwdata[RAD_W-1:0];
    end
  end

  // Twice the radius in Q.10 and its square
  assign span      = {radius_r, 11'b0};
  assign span2_nxt = span * span;
  always_ff @(posedge clk) begin
    span2_r <= span2_nxt;
  end

  // Flow control
  logic vld88, out_load, adv;
  logic out_tvalid_r, hit_r;
  logic [2:0] verdict_r;

  assign out_load  = !out_tvalid_r || out_tready;
  assign adv       = out_load || !vld88;
  assign in_tready = adv;

  // Input fields
  logic [POS_W-1:0] f_first_x, f_first_y, f_second_x, f_second_y;
  logic [SPD_W-1:0] f_first_speed, f_second_speed;
  logic [HDG_W-1:0] f_first_heading, f_second_heading;

  assign f_first_x        = in_tdata[15:0];
  assign f_first_y        = in_tdata[31:16];
  assign f_first_speed    = in_tdata[47:32];
  assign f_first_heading  = in_tdata[63:48];
  assign f_second_x       = in_tdata[79:64];
  assign f_second_y       = in_tdata[95:80];
  assign f_second_speed   = in_tdata[111:96];
  assign f_second_heading = in_tdata[127:112];

  // Velocity lanes
  logic                    v1_vld, v2_vld;
  logic signed [VEL_W-1:0] v1x, v1y, v2x, v2y;

  mcct_cordic u_lane1 (
    .clk, .rst_n, .ce(adv), .in_vld(in_tvalid),
    .in_speed(f_first_speed), .in_heading(f_first_heading),
    .out_vld(v1_vld), .out_vx(v1x), .out_vy(v1y)
  );

  mcct_cordic u_lane2 (
    .clk, .rst_n, .ce(adv), .in_vld(in_tvalid),
    .in_speed(f_second_speed), .in_heading(f_second_heading),
    .out_vld(v2_vld), .out_vx(v2x), .out_vy(v2y)
  );

  // Center offset in Q.10, delayed to meet the lanes
  logic signed [DIFF_W-1:0] cxd_r [CORDIC_LAT];
  logic signed [DIFF_W-1:0] cyd_r [CORDIC_LAT];
  logic signed [POS_W:0]    dx, dy;

  assign dx = $signed({1'b0, f_second_x}) - $signed({1'b0, f_first_x});
  assign dy = $signed({1'b0, f_second_y}) - $signed({1'b0, f_first_y});

  always_ff @(posedge clk) begin
    if (adv) begin
      cxd_r[0] <= {dx, 4'b0};
      cyd_r[0] <= {dy, 4'b0};
      for (int i = 1; i < CORDIC_LAT; i++) begin
        cxd_r[i] <= cxd_r[i-1];
        cyd_r[i] <= cyd_r[i-1];
      end
    end
  end

  // Relative velocity
  logic                     vld17_r;
  logic signed [RVEL_W-1:0] rvx_r, rvy_r;
  logic signed [DIFF_W-1:0] cx17_r, cy17_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld17_r <= 1'b0;
    end else if (adv) begin
      vld17_r <= v1_vld && v2_vld;
    end
    if (adv) begin
      rvx_r  <= RVEL_W'(v1x) - RVEL_W'(v2x);
      rvy_r  <= RVEL_W'(v1y) - RVEL_W'(v2y);
      cx17_r <= cxd_r[CORDIC_LAT-1];
      cy17_r <= cyd_r[CORDIC_LAT-1];
    end
  end

  // Squares and dot terms
  logic signed [2*RVEL_W-1:0]       mrx, mry;
  logic signed [2*DIFF_W-1:0]       mcx, mcy;
  logic signed [RVEL_W+DIFF_W-1:0]  mdx, mdy;
  logic                             vld18_r;
  logic [M2_W-1:0]                  rsqx_r, rsqy_r;
  logic [C2_W-1:0]                  csqx_r, csqy_r;
  logic signed [RVEL_W+DIFF_W-1:0]  dotx_r, doty_r;

  assign mrx = rvx_r * rvx_r;
  assign mry = rvy_r * rvy_r;
  assign mcx = cx17_r * cx17_r;
  assign mcy = cy17_r * cy17_r;
  assign mdx = rvx_r * cx17_r;
  assign mdy = rvy_r * cy17_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld18_r <= 1'b0;
    end else if (adv) begin
      vld18_r <= vld17_r;
    end
    if (adv) begin
      rsqx_r <= mrx[M2_W-1:0];
      rsqy_r <= mry[M2_W-1:0];
      csqx_r <= mcx[C2_W-1:0];
      csqy_r <= mcy[C2_W-1:0];
      dotx_r <= mdx;
      doty_r <= mdy;
    end
  end

  // Sums
  logic            vld19_r;
  logic [M2_W-1:0] m2_r;
  side_t           side19_r;
  side_t           side19_nxt;

  always_comb begin
    side19_nxt     = '0;
    side19_nxt.c2  = csqx_r + csqy_r;
    side19_nxt.dot = DOT_W'(dotx_r) + DOT_W'(doty_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld19_r <= 1'b0;
    end else if (adv) begin
      vld19_r <= vld18_r;
    end
    if (adv) begin
      m2_r     <= rsqx_r + rsqy_r;
      side19_r <= side19_nxt;
    end
  end

  // Center distance and relative speed
  logic                  va, vb;
  logic [SQRT_OUT_W-1:0] root_a, root_b;
  side_t                 side_a, side_b;

  mcct_sqrt u_sqrt_dis (
    .clk, .rst_n, .ce(adv), .in_vld(vld19_r),
    .in_rad({{(SQRT_IN_W-C2_W){1'b0}}, side19_r.c2}), .in_side(side19_r),
    .out_vld(va), .out_root(root_a), .out_side(side_a)
  );

  mcct_sqrt u_sqrt_mag (
    .clk, .rst_n, .ce(adv), .in_vld(vld19_r),
    .in_rad({{(SQRT_IN_W-M2_W){1'b0}}, m2_r}), .in_side(side19_r),
    .out_vld(vb), .out_root(root_b), .out_side(side_b)
  );

  // Too-far and receding tests
  logic [MAG_W-1:0] magc;
  logic [DIS_W:0]   far_lim;
  logic             vld42_r;
  side_t            side42_r;
  side_t            side42_nxt;

  assign magc    = (root_b[MAG_W-1:0] == '0) ? MAG_W'(1) : root_b[MAG_W-1:0];
  assign far_lim = (DIS_W+1)'(span) + (DIS_W+1)'(magc);

  always_comb begin
    side42_nxt        = '0;
    side42_nxt.c2     = side_a.c2;
    side42_nxt.dot    = side_b.dot;
    side42_nxt.mag    = magc;
    side42_nxt.far    = ({1'b0, root_a[DIS_W-1:0]} > far_lim);
    side42_nxt.recede = side_b.dot[DOT_W-1] || (side_b.dot == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld42_r <= 1'b0;
    end else if (adv) begin
      vld42_r <= va && vb;
    end
    if (adv) begin
      side42_r <= side42_nxt;
    end
  end

  // Projection of the offset on the relative velocity
  logic               vld64;
  logic [DIV_Q_W-1:0] quo;
  side_t              side64;

  mcct_div u_div (
    .clk, .rst_n, .ce(adv), .in_vld(vld42_r),
    .in_dvd(side42_r.dot[DIV_DVD_W-1:0]), .in_dvs(side42_r.mag),
    .in_side(side42_r),
    .out_vld(vld64), .out_quo(quo), .out_side(side64)
  );

  // Squared projection
  logic [2*DIV_Q_W-1:0] psq;
  logic                 vld65_r;
  logic [2*DIV_Q_W-1:0] psq_r;
  side_t                side65_r;
  side_t                side65_nxt;

  assign psq = quo * quo;

  always_comb begin
    side65_nxt      = side64;
    side65_nxt.proj = quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld65_r <= 1'b0;
    end else if (adv) begin
      vld65_r <= vld64;
    end
    if (adv) begin
      psq_r    <= psq;
      side65_r <= side65_nxt;
    end
  end

  // Closest-approach offset test
  logic signed [OFF_W-1:0] off, rad_full;
  logic                    vld66_r;
  logic [SQRT_IN_W-1:0]    rad_r;
  side_t                   side66_r;
  side_t                   side66_nxt;

  assign off      = $signed({{(OFF_W-C2_W){1'b0}}, side65_r.c2}) -
                    $signed({{(OFF_W-2*DIV_Q_W){1'b0}}, psq_r});
  assign rad_full = $signed({{(OFF_W-SPAN2_W){1'b0}}, span2_r}) - off;

  always_comb begin
    side66_nxt         = side65_r;
    side66_nxt.offmiss = (off > $signed({{(OFF_W-SPAN2_W){1'b0}}, span2_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld66_r <= 1'b0;
    end else if (adv) begin
      vld66_r <= vld65_r;
    end
    if (adv) begin
      rad_r    <= rad_full[SQRT_IN_W-1:0];
      side66_r <= side66_nxt;
    end
  end

  // Contact depth root
  logic [SQRT_OUT_W-1:0] root_c;
  side_t                 side88;

  mcct_sqrt u_sqrt_depth (
    .clk, .rst_n, .ce(adv), .in_vld(vld66_r),
    .in_rad(rad_r), .in_side(side66_r),
    .out_vld(vld88), .out_root(root_c), .out_side(side88)
  );

  // Final verdict and output register
  logic [SQRT_OUT_W:0] depth_lim;
  logic                beyond;
  logic [2:0]          verdict_nxt;

  assign depth_lim = (SQRT_OUT_W+1)'(root_c) + (SQRT_OUT_W+1)'(side88.mag);
  assign beyond    = ({1'b0, side88.proj} > depth_lim);

  always_comb begin
    if (side88.far) begin
      verdict_nxt = VERDICT_FAR;
    end else if (side88.recede) begin
      verdict_nxt = VERDICT_RECEDE;
    end else if (side88.offmiss) begin
      verdict_nxt = VERDICT_OFFSET;
    end else if (beyond) begin
      verdict_nxt = VERDICT_BEYOND;
    end else begin
      verdict_nxt = VERDICT_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= vld88;
    end
    if (out_load) begin
      verdict_r <= verdict_nxt;
      hit_r     <= (verdict_nxt == VERDICT_HIT);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, verdict_r, hit_r};

endmodule
`default_nettype wire

// ===== rtl/core/mcct_checker.sv =====
// Port-level checks for the collision test, bound to the top level.
`default_nettype none
module mcct_checker import mcct_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Hit flag agrees with the verdict code
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == VERDICT_HIT)))
    else $error("hit flag and verdict disagree");

  // Only defined verdict codes, with the upper bits zero, leave the block
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:1] <= VERDICT_BEYOND && out_tdata[7:4] == 4'b0))
    else $error("undefined verdict code");

endmodule

bind moving_circle_collision_test mcct_checker u_mcct_checker (.*);
`default_nettype wire
